### rtl/assert_macros.svh
// Assertion macros shared by the cache lookup RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge outside reset.
`define DMC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define DMC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DMC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dmc_pkg.sv
// Package for the direct-mapped cache lookup: widths, limits, register codes, types.
// No dependencies; used by the interfaces, the address splitter and the top level.
package dmc_pkg;

  localparam int WORD_W      = 32;
  localparam int ADDR_WIDTH  = 32;   // address bits kept before the split
  localparam int OFF_FIELD_W = 16;
  localparam int IDX_FIELD_W = 10;
  localparam int OFF_LIMIT   = 16;   // larger offset widths saturate here
  localparam int IDX_LIMIT   = 10;   // larger index widths saturate here

  localparam int DMC_MAX_LINES = 1024;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int OW_REG_W   = 5;
  localparam int IW_REG_W   = 4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_WIDTH  = CFG_IDX_W'(1);
  localparam logic [OW_REG_W-1:0]  OW_RESET = OW_REG_W'(2);
  localparam logic [IW_REG_W-1:0]  IW_RESET = IW_REG_W'(4);

  localparam logic [WORD_W-1:0] ADDR_MASK =
    (ADDR_WIDTH >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << ADDR_WIDTH) - 64'd1);

  typedef struct packed {
    logic [WORD_W-1:0]      tag;
    logic [IDX_FIELD_W-1:0] idx;
    logic [OFF_FIELD_W-1:0] offset;
    logic [WORD_W-1:0]      block;
  } dmc_fields_t;

  typedef struct packed {
    logic                   hit;
    logic                   evicted;
    logic [WORD_W-1:0]      addr_tag;
    logic [IDX_FIELD_W-1:0] line_index;
    logic [OFF_FIELD_W-1:0] byte_offset;
    logic [WORD_W-1:0]      block_number;
    logic [WORD_W-1:0]      hit_count;
    logic [WORD_W-1:0]      miss_count;
    logic [WORD_W-1:0]      eviction_count;
  } dmc_result_t;

endpackage

### rtl/dmc_if.sv
// Valid/ready channel interfaces for the cache lookup: address in, lookup result out.
// Depends on dmc_pkg for field widths.
interface dmc_in_if import dmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface dmc_out_if import dmc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic                   evicted;
  logic [WORD_W-1:0]      addr_tag;
  logic [IDX_FIELD_W-1:0] line_index;
  logic [OFF_FIELD_W-1:0] byte_offset;
  logic [WORD_W-1:0]      block_number;
  logic [WORD_W-1:0]      hit_count;
  logic [WORD_W-1:0]      miss_count;
  logic [WORD_W-1:0]      eviction_count;

  modport source (output valid, output hit, output evicted, output addr_tag,
                  output line_index, output byte_offset, output block_number,
                  output hit_count, output miss_count, output eviction_count,
                  input ready);
  modport sink   (input valid, input hit, input evicted, input addr_tag,
                  input line_index, input byte_offset, input block_number,
                  input hit_count, input miss_count, input eviction_count,
                  output ready);
endinterface

### rtl/dmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dmc_addr_split.sv
// Splits an address into offset, line index, tag and block number.
// Depends on dmc_pkg; widths saturate at the offset and index limits.
module dmc_addr_split import dmc_pkg::*; (
  input  logic [WORD_W-1:0]   address_i,
  input  logic [OW_REG_W-1:0] offset_width_i,
  input  logic [IW_REG_W-1:0] index_width_i,
  output dmc_fields_t         fields_o
);

  logic [OW_REG_W-1:0] ow;
  logic [IW_REG_W-1:0] iw;
  logic [WORD_W-1:0]   addr_m;
  logic [WORD_W-1:0]   block;

  always_comb begin
    ow     = (offset_width_i > OW_REG_W'(OFF_LIMIT)) ? OW_REG_W'(OFF_LIMIT) : offset_width_i;
    iw     = (index_width_i > IW_REG_W'(IDX_LIMIT)) ? IW_REG_W'(IDX_LIMIT) : index_width_i;
    addr_m = address_i & ADDR_MASK;
    block  = addr_m >> ow;

    fields_o.block  = block;
    fields_o.offset = addr_m[OFF_FIELD_W-1:0] & ~({OFF_FIELD_W{1'b1}} << ow);
    fields_o.idx    = block[IDX_FIELD_W-1:0] & ~({IDX_FIELD_W{1'b1}} << iw);
    fields_o.tag    = block >> iw;
  end

endmodule

### rtl/direct_mapped_cache_lookup.sv
// Direct-mapped cache tag store: top level, sequencer, counters, line RAM.
// Depends on dmc_pkg, dmc_if, dmc_addr_split, dmc_ram and assert_macros.svh.
//
//   channel | dir | handshake     | word
//   --------+-----+---------------+-------------------------------------------
//   in_i    | in  | valid/ready   | address
//   out_o   | out | valid/ready   | hit, evicted, fields, three counters
//   cfg     | in  | cfg_we_i only | cfg_index_i, cfg_data_i
//
// An access steps through accept, quotient, line reduce, RAM read, compare
// and write back. The sequencer sets the pace; one access is in
// flight at a time. The next address is taken while a result waits on out_o.
// After reset a clearing pass writes MAX_LINES entries, one per cycle, with
// in_i.ready low. out_o holds its word until taken.
`include "assert_macros.svh"

module direct_mapped_cache_lookup import dmc_pkg::*; #(
  parameter int MAX_LINES = DMC_MAX_LINES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dmc_in_if.sink                in_i,
  dmc_out_if.source             out_o
);

  localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int RAM_W   = WORD_W + 1;            // {valid, tag}
  localparam int RECIP_W = IDX_FIELD_W + 1;
  localparam int PROD_W  = IDX_FIELD_W + RECIP_W;
  localparam int MW      = $clog2(MAX_LINES + 1);
  localparam int REM_W   = IDX_FIELD_W + 1;
  localparam int CW      = (MW > REM_W) ? MW : REM_W;
  // floor(2^IDX_FIELD_W / MAX_LINES): quotient estimate is at most one low
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((2 ** IDX_FIELD_W) / MAX_LINES);
  localparam logic [MW-1:0]      MOD_C   = MW'(MAX_LINES);
  localparam logic [CW-1:0]      MOD_CW  = CW'(MAX_LINES);
  localparam logic [LINE_W-1:0]  LAST_LN = LINE_W'(MAX_LINES - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_QUOT = 3'd1;
  localparam logic [2:0] ST_LINE = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic                  clr_active_q, clr_active_d;
  logic [LINE_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic [OW_REG_W-1:0]   ow_q;
  logic [IW_REG_W-1:0]   iw_q;
  logic [WORD_W-1:0]     hits_q, hits_d;
  logic [WORD_W-1:0]     misses_q, misses_d;
  logic [WORD_W-1:0]     evicts_q, evicts_d;
  logic                  out_valid_q, out_valid_d;

  dmc_fields_t           split;
  dmc_fields_t           fld_q;
  logic [IDX_FIELD_W-1:0] quot_q;
  logic [LINE_W-1:0]     line_q;
  dmc_result_t           res_q, res_d;

  logic                  in_acc;
  logic                  res_load;
  logic [PROD_W-1:0]     prod;
  logic [IDX_FIELD_W+MW-1:0] qm;
  logic [REM_W-1:0]      rem;
  logic [CW-1:0]         rem_c;
  logic [LINE_W-1:0]     line_d;
  logic                  ram_we, ram_re;
  logic [LINE_W-1:0]     ram_waddr;
  logic [RAM_W-1:0]      ram_wdata, ram_rdata;
  logic                  line_valid, hit, evicted;

  dmc_addr_split u_split (
    .address_i      (in_i.address),
    .offset_width_i (ow_q),
    .index_width_i  (iw_q),
    .fields_o       (split)
  );

  dmc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (line_q),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE) && !clr_active_q;
  assign in_acc     = in_i.valid && in_i.ready;

  // line = idx mod MAX_LINES via reciprocal, then one correcting subtract
  assign prod  = PROD_W'(fld_q.idx) * PROD_W'(RECIP);
  assign qm    = (IDX_FIELD_W+MW)'(quot_q) * (IDX_FIELD_W+MW)'(MOD_C);
  assign rem   = REM_W'(fld_q.idx) - qm[REM_W-1:0];
  assign rem_c = CW'(rem);
  assign line_d = (rem_c >= MOD_CW) ? LINE_W'(rem_c - MOD_CW) : LINE_W'(rem_c);

  assign line_valid = ram_rdata[RAM_W-1];
  assign hit        = line_valid && (ram_rdata[WORD_W-1:0] == fld_q.tag);
  assign evicted    = line_valid && !hit;
  assign res_load   = (state_q == ST_CMP) && (!out_valid_q || out_o.ready);

  assign ram_re    = (state_q == ST_READ);
  assign ram_we    = clr_active_q || (res_load && !hit);
  assign ram_waddr = clr_active_q ? clr_cnt_q : line_q;
  assign ram_wdata = clr_active_q ? '0 : {1'b1, fld_q.tag};

  always_comb begin
    state_d      = state_q;
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    hits_d       = hits_q;
    misses_d     = misses_q;
    evicts_d     = evicts_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    res_d        = res_q;

    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + LINE_W'(1);
      if (clr_cnt_q == LAST_LN) begin
        clr_active_d = 1'b0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_QUOT;
        end
      end
      ST_QUOT: state_d = ST_LINE;
      ST_LINE: state_d = ST_READ;
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (res_load) begin
          hits_d   = hits_q + WORD_W'(hit);
          misses_d = misses_q + WORD_W'(!hit);
          evicts_d = evicts_q + WORD_W'(evicted);
          res_d.hit            = hit;
          res_d.evicted        = evicted;
          res_d.addr_tag       = fld_q.tag;
          res_d.line_index     = fld_q.idx;
          res_d.byte_offset    = fld_q.offset;
          res_d.block_number   = fld_q.block;
          res_d.hit_count      = hits_d;
          res_d.miss_count     = misses_d;
          res_d.eviction_count = evicts_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      ow_q         <= OW_RESET;
      iw_q         <= IW_RESET;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      hits_q       <= hits_d;
      misses_q     <= misses_d;
      evicts_q     <= evicts_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_OFFSET_WIDTH: ow_q <= cfg_data_i[OW_REG_W-1:0];
          REG_INDEX_WIDTH:  iw_q <= cfg_data_i[IW_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fld_q <= split;
    end
    if (state_q == ST_QUOT) begin
      quot_q <= prod[IDX_FIELD_W +: IDX_FIELD_W];
    end
    if (state_q == ST_LINE) begin
      line_q <= line_d;
    end
    res_q <= res_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.hit            = res_q.hit;
  assign out_o.evicted        = res_q.evicted;
  assign out_o.addr_tag       = res_q.addr_tag;
  assign out_o.line_index     = res_q.line_index;
  assign out_o.byte_offset    = res_q.byte_offset;
  assign out_o.block_number   = res_q.block_number;
  assign out_o.hit_count      = res_q.hit_count;
  assign out_o.miss_count     = res_q.miss_count;
  assign out_o.eviction_count = res_q.eviction_count;

  `DMC_ASSERT_IMP(a_hit_xor_evict, clk_i, rst_ni, out_valid_q, !(res_q.hit && res_q.evicted), "hit and eviction on one word")
  `DMC_ASSERT_NXT(a_one_count_step, clk_i, rst_ni, res_load, (hits_q + misses_q) == ($past(hits_q) + $past(misses_q) + 32'd1), "hit plus miss count did not step by one")
  `DMC_ASSERT_IMP(a_no_accept_clr, clk_i, rst_ni, clr_active_q, !in_i.ready, "address taken during clearing pass")
  `DMC_ASSERT_IMP(a_ram_write_src, clk_i, rst_ni, ram_we, clr_active_q || (state_q == ST_CMP), "tag RAM written outside compare or clear")

endmodule

### tb/direct_mapped_cache_lookup_tb.sv
// Self-checking testbench for direct_mapped_cache_lookup: address words in, lookup words out.
// Depends on dmc_pkg, dmc_in_if/dmc_out_if and the cache lookup RTL; keeps its own tag mirror.
`timescale 1ns / 1ps

module direct_mapped_cache_lookup_tb;
  import dmc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 195;
  // indexes past the two real registers; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dmc_in_if  addr_ch();
  dmc_out_if res_ch();

  direct_mapped_cache_lookup dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (addr_ch),
    .out_o       (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the tag store and its registers
  logic [OW_REG_W-1:0] off_w_reg;
  logic [IW_REG_W-1:0] idx_w_reg;
  bit                  line_present [DMC_MAX_LINES];
  logic [WORD_W-1:0]   line_tag_mirror [DMC_MAX_LINES];
  logic [WORD_W-1:0]   hits_seen, misses_seen, evicts_seen;

  logic [WORD_W-1:0] addr_pending_q [$];
  dmc_result_t       lookup_expect_q [$];
  logic [WORD_W-1:0] recent_addr [$];

  int   addr_issued;
  int   addr_taken;
  int   mismatches;
  int   cycle_cnt;
  int   send_idle_pct;
  int   rcv_stall_pct;
  logic rcv_hold;
  event rcv_hold_ev;

  function automatic void eff_widths(output int unsigned ow, output int unsigned iw);
    ow = (off_w_reg > OFF_LIMIT) ? OFF_LIMIT : off_w_reg;
    iw = (idx_w_reg > IDX_LIMIT) ? IDX_LIMIT : idx_w_reg;
  endfunction

  function automatic dmc_result_t predict_lookup(logic [WORD_W-1:0] address);
    int unsigned       ow, iw, slot;
    logic [WORD_W-1:0] a, blk, tg;
    dmc_result_t       r;
    eff_widths(ow, iw);
    a   = address & ADDR_MASK;
    blk = a >> ow;
    tg  = blk >> iw;
    r   = '0;
    r.addr_tag     = tg;
    r.byte_offset  = OFF_FIELD_W'(a & ((32'd1 << ow) - 32'd1));
    r.line_index   = IDX_FIELD_W'(blk & ((32'd1 << iw) - 32'd1));
    r.block_number = blk;
    slot = r.line_index % DMC_MAX_LINES;
    if (!line_present[slot]) begin
      misses_seen++;
      line_present[slot] = 1'b1;
      line_tag_mirror[slot] = tg;
    end else if (line_tag_mirror[slot] != tg) begin
      misses_seen++;
      evicts_seen++;
      r.evicted = 1'b1;
      line_tag_mirror[slot] = tg;
    end else begin
      hits_seen++;
      r.hit = 1'b1;
    end
    r.hit_count      = hits_seen;
    r.miss_count     = misses_seen;
    r.eviction_count = evicts_seen;
    return r;
  endfunction

  // Mostly revisits of recent addresses: same block (hit), same line with
  // another tag (eviction); the rest random, a quarter kept to the low 16 bits.
  function automatic logic [WORD_W-1:0] gen_address();
    int unsigned       ow, iw, pick;
    logic [WORD_W-1:0] a;
    eff_widths(ow, iw);
    pick = $urandom_range(99);
    if (recent_addr.size() == 0 || pick >= 75) begin
      a = $urandom;
      if ($urandom_range(3) == 0) a = a & 32'h0000_ffff;
    end else begin
      a = recent_addr[$urandom_range(recent_addr.size() - 1)];
      if (pick < 45) a = a ^ ($urandom & ((32'd1 << ow) - 32'd1));
      else           a = a ^ ($urandom << (ow + iw));
    end
    recent_addr.push_back(a);
    if (recent_addr.size() > 12) void'(recent_addr.pop_front());
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    $display("MISMATCH @%0t %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic queue_address(logic [WORD_W-1:0] a);
    addr_pending_q.push_back(a);
    addr_issued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (addr_taken != addr_issued || lookup_expect_q.size() != 0);
  endtask

  task automatic set_idling(int send_pct, int rcv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    rcv_stall_pct <= rcv_pct;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_OFFSET_WIDTH)     off_w_reg = val[OW_REG_W-1:0];
    else if (idx == REG_INDEX_WIDTH) idx_w_reg = val[IW_REG_W-1:0];
  endtask

  // address driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_ch.valid   <= 1'b0;
      addr_ch.address <= '0;
    end else begin
      if (addr_ch.valid && addr_ch.ready) begin
        lookup_expect_q.push_back(predict_lookup(addr_ch.address));
        addr_taken++;
      end
      if (!addr_ch.valid || addr_ch.ready) begin
        if (addr_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          addr_ch.valid   <= 1'b1;
          addr_ch.address <= addr_pending_q.pop_front();
        end else begin
          addr_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !rcv_hold && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // long receiver hold-off, counted here
  always begin
    @(rcv_hold_ev);
    rcv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rcv_hold <= 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin : result_monitor
    dmc_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (lookup_expect_q.size() == 0) begin
        report_mismatch("result word with none pending", res_ch.block_number, '0);
      end else begin
        want = lookup_expect_q.pop_front();
        check_field("hit",            WORD_W'(res_ch.hit),         WORD_W'(want.hit));
        check_field("evicted",        WORD_W'(res_ch.evicted),     WORD_W'(want.evicted));
        check_field("addr_tag",       res_ch.addr_tag,             want.addr_tag);
        check_field("line_index",     WORD_W'(res_ch.line_index),  WORD_W'(want.line_index));
        check_field("byte_offset",    WORD_W'(res_ch.byte_offset), WORD_W'(want.byte_offset));
        check_field("block_number",   res_ch.block_number,         want.block_number);
        check_field("hit_count",      res_ch.hit_count,            want.hit_count);
        check_field("miss_count",     res_ch.miss_count,           want.miss_count);
        check_field("eviction_count", res_ch.eviction_count,       want.eviction_count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_ow [RAND_PHASES];
    int phase_iw [RAND_PHASES];
    phase_ow = '{2, 0, 5, 16, 0, 7, 20, 31};
    phase_iw = '{4, 0, 3, 10, 10, 8, 12, 0};

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_OFFSET_WIDTH;
    cfg_data_i      = '0;
    addr_ch.valid   = 1'b0;
    addr_ch.address = '0;
    res_ch.ready    = 1'b0;
    rcv_hold        = 1'b0;
    send_idle_pct   = 0;
    rcv_stall_pct   = 0;
    addr_issued     = 0;
    addr_taken      = 0;
    mismatches      = 0;
    cycle_cnt       = 0;
    off_w_reg       = OW_RESET;
    idx_w_reg       = IW_RESET;
    hits_seen       = '0;
    misses_seen     = '0;
    evicts_seen     = '0;
    foreach (line_present[i]) line_present[i] = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset widths: fill, hit, eviction by offset-only and tag changes
    queue_address(32'h0000_0000);
    queue_address(32'h0000_0000);
    queue_address(32'h0000_0003);
    queue_address(32'h0000_0040);
    queue_address(32'h0000_0000);
    queue_address(32'hffff_ffff);
    queue_address(32'hffff_fffc);
    queue_address(32'haaaa_aaaa);
    queue_address(32'h5555_5555);
    wait_drained();

    // zero widths: one line, tag is the whole address
    write_reg(REG_OFFSET_WIDTH, '0);
    write_reg(REG_INDEX_WIDTH, '0);
    queue_address(32'h1234_5678);
    queue_address(32'h1234_5678);
    queue_address(32'hffff_ffff);
    wait_drained();

    // oversized widths saturate; spare register indexes do nothing
    write_reg(REG_OFFSET_WIDTH, 5'd31);
    write_reg(REG_INDEX_WIDTH, 5'd31);
    write_reg(REG_SPARE_2, 5'd31);
    write_reg(REG_SPARE_3, 5'd0);
    queue_address(32'hffff_ffff);
    queue_address(32'hffff_0000);
    queue_address(32'h0000_0000);
    queue_address(32'h0400_0000);
    wait_drained();

    write_reg(REG_OFFSET_WIDTH, 5'd16);
    write_reg(REG_INDEX_WIDTH, 5'd10);
    queue_address(32'hffff_ffff);
    wait_drained();

    // receiver held off while the sender keeps offering words
    write_reg(REG_OFFSET_WIDTH, 5'd2);
    write_reg(REG_INDEX_WIDTH, 5'd4);
    set_idling(0, 0);
    -> rcv_hold_ev;
    repeat (40) queue_address(gen_address());
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(REG_OFFSET_WIDTH, CFG_DATA_W'(phase_ow[p]));
      write_reg(REG_INDEX_WIDTH, CFG_DATA_W'(phase_iw[p]));
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(55, 0);
        2: set_idling(0, 55);
        default: set_idling(20, 20);
      endcase
      repeat (PHASE_ITEMS) queue_address(gen_address());
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
